[src/ifse_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifse_pkg: shared types and constants of the information frame encoder
// Holds the frame job word, the register block type, sequencer step codes
// and the escape test used by the output sequencer.
// ----------------------------------------------------------------------------
package ifse_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_FLAG    = 2'd0;
    localparam logic [1:0] CFG_ESCAPE  = 2'd1;
    localparam logic [1:0] CFG_MASK    = 2'd2;
    localparam logic [1:0] CFG_ADDRESS = 2'd3;

    // Register reset values
    localparam logic [7:0] FLAG_RST    = 8'h7E;
    localparam logic [7:0] ESCAPE_RST  = 8'h7D;
    localparam logic [7:0] MASK_RST    = 8'h20;
    localparam logic [7:0] ADDRESS_RST = 8'h03;

    // Control byte by sequence bit
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;
    localparam logic [7:0] CTRL_SEQ1 = 8'h40;

    // Output sequencer steps
    localparam logic [3:0] STEP_START  = 4'd0;
    localparam logic [3:0] STEP_FLAG   = 4'd1;
    localparam logic [3:0] STEP_ADDR   = 4'd2;
    localparam logic [3:0] STEP_CTRL   = 4'd3;
    localparam logic [3:0] STEP_BCC1   = 4'd4;
    localparam logic [3:0] STEP_DATA   = 4'd5;
    localparam logic [3:0] STEP_DATA_X = 4'd6;
    localparam logic [3:0] STEP_BCC2   = 4'd7;
    localparam logic [3:0] STEP_BCC2_X = 4'd8;
    localparam logic [3:0] STEP_CLOSE  = 4'd9;

    // Register block as seen by the sequencer
    typedef struct packed {
        logic [7:0] flag_value;
        logic [7:0] escape_value;
        logic [7:0] stuff_mask;
        logic [7:0] address_value;
    } ifse_cfg_t;

    // One classified payload word with its block check
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
        logic       seq_bit;
        logic [7:0] bcc2;
    } ifse_job_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } ifse_qstat_t;

    // True when a byte must go out as an escape pair
    function automatic logic needs_escape(logic [7:0] b, ifse_cfg_t c);
        needs_escape = (b == c.flag_value) || (b == c.escape_value);
    endfunction

endpackage

[src/ifse_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifse_front: input stage of the information frame encoder
// Accepts payload words, keeps the running XOR parity of the frame and
// pushes each word with its block check into the job queue.
// ----------------------------------------------------------------------------
module ifse_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           payload_byte,
    input  logic                 first_byte,
    input  logic                 last_byte,
    input  logic                 seq_bit,
    input  ifse_pkg::ifse_qstat_t qstat,
    output logic                 push,
    output ifse_pkg::ifse_job_t  job
);

    logic [7:0] parity_reg;
    logic [7:0] parity_next;
    logic [7:0] parity_word;

    // Take a word whenever the queue has room
    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    // Restart parity on a first word, else fold the word in
    assign parity_word = first_byte ? payload_byte : (parity_reg ^ payload_byte);

    always_comb
    begin
        parity_next = parity_reg;
        if (push)
        begin
            parity_next = last_byte ? 8'h00 : parity_word;
        end
    end

    // Build the queued job
    always_comb
    begin
        job.payload_byte = payload_byte;
        job.first_byte   = first_byte;
        job.last_byte    = last_byte;
        job.seq_bit      = seq_bit;
        job.bcc2         = parity_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 8'h00;
        end
        else
        begin
            parity_reg <= parity_next;
        end
    end

endmodule

[src/ifse_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifse_queue: two-entry job queue
// Decouples word intake from the byte sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
module ifse_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ifse_pkg::ifse_job_t   push_job,
    input  logic                  pop,
    output ifse_pkg::ifse_job_t   head,
    output ifse_pkg::ifse_qstat_t qstat
);

    ifse_pkg::ifse_job_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/ifse_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifse_back: output byte sequencer
// Walks header (first word), stuffed payload and BCC2, closing flag (last
// word) of the head job to the output register, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module ifse_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ifse_pkg::ifse_cfg_t   cfg,
    input  ifse_pkg::ifse_job_t   head,
    input  ifse_pkg::ifse_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  end_of_frame
);

    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       eof_reg;

    logic [3:0] cur_step;
    logic [3:0] step_after;
    logic       done;
    logic       emit;
    logic [7:0] byte_val;
    logic       eof_val;
    logic [7:0] ctrl;
    logic       data_esc;
    logic       bcc_esc;

    assign ctrl     = head.seq_bit ? ifse_pkg::CTRL_SEQ1 : ifse_pkg::CTRL_SEQ0;
    assign data_esc = ifse_pkg::needs_escape(head.payload_byte, cfg);
    assign bcc_esc  = ifse_pkg::needs_escape(head.bcc2, cfg);

    // Pick the entry step of a fresh job
    always_comb
    begin
        if (step_reg == ifse_pkg::STEP_START)
        begin
            cur_step = head.first_byte ? ifse_pkg::STEP_FLAG : ifse_pkg::STEP_DATA;
        end
        else
        begin
            cur_step = step_reg;
        end
    end

    // Produce the byte of the current step and the step after it
    always_comb
    begin
        byte_val   = 8'h00;
        eof_val    = 1'b0;
        step_after = ifse_pkg::STEP_START;
        done       = 1'b0;
        case (cur_step)
            ifse_pkg::STEP_FLAG:
            begin
                byte_val   = cfg.flag_value;
                step_after = ifse_pkg::STEP_ADDR;
            end
            ifse_pkg::STEP_ADDR:
            begin
                byte_val   = cfg.address_value;
                step_after = ifse_pkg::STEP_CTRL;
            end
            ifse_pkg::STEP_CTRL:
            begin
                byte_val   = ctrl;
                step_after = ifse_pkg::STEP_BCC1;
            end
            ifse_pkg::STEP_BCC1:
            begin
                byte_val   = cfg.address_value ^ ctrl;
                step_after = ifse_pkg::STEP_DATA;
            end
            ifse_pkg::STEP_DATA:
            begin
                if (data_esc)
                begin
                    byte_val   = cfg.escape_value;
                    step_after = ifse_pkg::STEP_DATA_X;
                end
                else
                begin
                    byte_val   = head.payload_byte;
                    step_after = ifse_pkg::STEP_BCC2;
                    done       = !head.last_byte;
                end
            end
            ifse_pkg::STEP_DATA_X:
            begin
                byte_val   = head.payload_byte ^ cfg.stuff_mask;
                step_after = ifse_pkg::STEP_BCC2;
                done       = !head.last_byte;
            end
            ifse_pkg::STEP_BCC2:
            begin
                if (bcc_esc)
                begin
                    byte_val   = cfg.escape_value;
                    step_after = ifse_pkg::STEP_BCC2_X;
                end
                else
                begin
                    byte_val   = head.bcc2;
                    step_after = ifse_pkg::STEP_CLOSE;
                end
            end
            ifse_pkg::STEP_BCC2_X:
            begin
                byte_val   = head.bcc2 ^ cfg.stuff_mask;
                step_after = ifse_pkg::STEP_CLOSE;
            end
            ifse_pkg::STEP_CLOSE:
            begin
                byte_val = cfg.flag_value;
                eof_val  = 1'b1;
                done     = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    // Emit when a job waits and the output register frees up
    assign emit = !qstat.empty && (!out_valid_reg || out_ready);
    assign pop  = emit && done;

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            step_next      = done ? ifse_pkg::STEP_START : step_after;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ifse_pkg::STEP_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= byte_val;
            eof_reg      <= eof_val;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign end_of_frame = eof_reg;

endmodule

[src/info_frame_stuffing_encoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_frame_stuffing_encoder_top: information frame framer with stuffing
// Wraps payload words into flag-delimited frames with header, byte stuffing
// and XOR block checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one payload word per handshake,
//   tagged first_byte, last_byte and seq_bit. Output channel
//   (out_valid/out_ready) delivers the framed bytes of each word; end_of_frame
//   marks the closing flag.
//   A first word adds four header bytes (flag, address, control, BCC1);
//   a last word adds BCC2 (one or two bytes) and the closing flag.
//   Throughput is one output byte per cycle while jobs wait and the receiver
//   does not stall, set by the byte sequencer: a plain mid-frame word gives
//   one byte, an escaped word two, plus four for a header and two to three
//   for a trailer.
//   A word accepted while the output side is idle is first written into
//   the job queue, then its first byte is loaded into the output register
//   and out_valid rises.
//   A two-entry job queue lets intake take up to two words while the
//   receiver stalls; a stalled output word is held unchanged until taken.
//   Reset clears the parity, queue and sequencer and loads the default
//   register values. Write registers only while the block is idle.
// ----------------------------------------------------------------------------
module info_frame_stuffing_encoder_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] payload_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  logic       seq_bit,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       end_of_frame
);

    ifse_pkg::ifse_cfg_t   cfg_reg;
    ifse_pkg::ifse_cfg_t   cfg_next;
    ifse_pkg::ifse_job_t   push_job;
    ifse_pkg::ifse_job_t   head;
    ifse_pkg::ifse_qstat_t qstat;
    logic                  push;
    logic                  pop;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ifse_pkg::CFG_FLAG:    cfg_next.flag_value    = cfg_data;
                ifse_pkg::CFG_ESCAPE:  cfg_next.escape_value  = cfg_data;
                ifse_pkg::CFG_MASK:    cfg_next.stuff_mask    = cfg_data;
                ifse_pkg::CFG_ADDRESS: cfg_next.address_value = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_value    <= ifse_pkg::FLAG_RST;
            cfg_reg.escape_value  <= ifse_pkg::ESCAPE_RST;
            cfg_reg.stuff_mask    <= ifse_pkg::MASK_RST;
            cfg_reg.address_value <= ifse_pkg::ADDRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ifse_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .payload_byte (payload_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .seq_bit      (seq_bit),
        .qstat        (qstat),
        .push         (push),
        .job          (push_job)
    );

    ifse_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    ifse_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame)
    );

endmodule

[src/ifse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifse_checker: port-level checks of the information frame encoder
// Watches the output handshake, the intake-to-output timing and reset.
// ----------------------------------------------------------------------------
module ifse_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       end_of_frame
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(end_of_frame))
        else $error("output word changed while stalled");

    // Expect out_valid after any accepted word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("accepted word produced no output");

    // Nothing pending right after reset
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid out of reset");

endmodule

bind info_frame_stuffing_encoder_top ifse_checker u_ifse_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .end_of_frame (end_of_frame)
);
